FILE: hw/rtl/tkis_pkg.sv
// shared widths, record type and cell control types for the two-key insertion sorter
package tkis_pkg;

  localparam int HANDLE_W = 10;
  localparam int KEY_W    = 8;
  localparam int OFFSET_W = 16;

  // one stored record
  typedef struct packed {
    logic [HANDLE_W-1:0]        handle;
    logic [KEY_W-1:0]           key;
    logic signed [OFFSET_W-1:0] offset;
  } rec_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic load;   // insert the broadcast record
    logic shift;  // move every record one cell toward the head
  } cell_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic valid;
    logic flag;   // broadcast record belongs at or before this cell
    rec_t rec;
  } cell_out_t;

endpackage

FILE: hw/rtl/tkis_in_if.sv
// input channel: one record per beat
interface tkis_in_if import tkis_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [HANDLE_W-1:0]        object_handle;
  logic [KEY_W-1:0]           sort_key;
  logic signed [OFFSET_W-1:0] y_offset;
  logic                       last_item;

  modport source (output valid, object_handle, sort_key, y_offset, last_item, input ready);
  modport sink (input valid, object_handle, sort_key, y_offset, last_item, output ready);
endinterface

FILE: hw/rtl/tkis_out_if.sv
// output channel: one sorted record per beat
interface tkis_out_if import tkis_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [HANDLE_W-1:0]        out_handle;
  logic [KEY_W-1:0]           out_key;
  logic signed [OFFSET_W-1:0] out_offset;
  logic                       out_last;
  logic                       overflowed;

  modport source (output valid, out_handle, out_key, out_offset, out_last, overflowed,
                  input ready);
  modport sink (input valid, out_handle, out_key, out_offset, out_last, overflowed,
                output ready);
endinterface

FILE: hw/rtl/tkis_cell.sv
// one compare-and-shift cell of the sorted row
module tkis_cell import tkis_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  rec_t      ins_rec,
  input  cell_out_t left,
  input  cell_out_t right,
  output cell_out_t stat
);

  logic valid;
  rec_t rec;
  logic ahead;
  logic flag;

  // broadcast record sorts ahead of the one held here
  assign ahead = valid && ((rec.key < ins_rec.key) ||
                           ((rec.key == ins_rec.key) && (rec.offset > ins_rec.offset)));
  assign flag  = !valid || ahead;

  assign stat.valid = valid;
  assign stat.flag  = flag;
  assign stat.rec   = rec;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= right.valid;
    end else if (ctl.load && flag) begin
      valid <= left.flag ? left.valid : 1'b1;
    end
  end

  // record payload
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      rec <= right.rec;
    end else if (ctl.load && flag) begin
      rec <= left.flag ? left.rec : ins_rec;
    end
  end

endmodule

FILE: hw/rtl/two_key_insertion_sorter.sv
// top level: row of sorting cells with load and drain control
// Records enter one per cycle while the block is loading: each beat is compared in parallel
// against every cell of a row of CAPACITY compare-and-shift cells and lands in its place in
// the same cycle, the cells behind it moving one step down. The order is descending key, then
// ascending signed offset, and full ties stay in arrival order. A beat with last_item set is
// stored like any other, and from the next cycle the row drains from its head, one result per
// cycle while the sink is ready; the input is held off during the drain. Records that arrive
// with the row full are dropped and every result of that batch carries overflowed.
module two_key_insertion_sorter import tkis_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input logic        clk,
  input logic        rst,
  tkis_in_if.sink    items,
  tkis_out_if.source results
);

  cell_out_t            cells [CAPACITY];
  cell_out_t            lefts [CAPACITY];
  cell_out_t            rights[CAPACITY];
  logic [CAPACITY-1:0]  vld;
  cell_ctl_t            ctl;
  rec_t                 ins_rec;
  logic                 draining;
  logic                 overflow_seen;
  logic                 full;
  logic                 in_beat;
  logic                 out_beat;
  logic                 final_beat;

  // handshake and broadcast controls
  assign full       = cells[CAPACITY-1].valid;
  assign items.ready = !draining;
  assign in_beat    = items.valid && items.ready;
  assign out_beat   = results.valid && results.ready;
  assign final_beat = out_beat && results.out_last;

  assign ctl.load  = in_beat && !full;
  assign ctl.shift = out_beat;

  assign ins_rec.handle = items.object_handle;
  assign ins_rec.key    = items.sort_key;
  assign ins_rec.offset = items.y_offset;

  // cell row with neighbor links
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lefts[i] = '0;
    end else begin : g_link_l
      assign lefts[i] = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rights[i] = '0;
    end else begin : g_link_r
      assign rights[i] = cells[i+1];
    end
    assign vld[i] = cells[i].valid;

    tkis_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .ins_rec (ins_rec),
      .left    (lefts[i]),
      .right   (rights[i]),
      .stat    (cells[i])
    );
  end

  // drain mode
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (in_beat && items.last_item) begin
      draining <= 1'b1;
    end else if (final_beat) begin
      draining <= 1'b0;
    end
  end

  // dropped-record flag for the batch
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (in_beat && full) begin
      overflow_seen <= 1'b1;
    end else if (final_beat) begin
      overflow_seen <= 1'b0;
    end
  end

  // results come straight from the head cell
  assign results.valid      = draining && cells[0].valid;
  assign results.out_handle = cells[0].rec.handle;
  assign results.out_key    = cells[0].rec.key;
  assign results.out_offset = cells[0].rec.offset;
  assign results.out_last   = !cells[1].valid;
  assign results.overflowed = overflow_seen;

`ifndef SYNTH
  // row is filled from the head with no gaps
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, vld} + (CAPACITY + 1)'(1)))
    else $error("sorter cells not filled contiguously");

  // a drain always has a record at the head
  a_drain_head: assert property (@(posedge clk) disable iff (rst)
    draining |-> cells[0].valid)
    else $error("drain with empty head cell");

  // the final result empties the row and ends the drain
  a_final_empty: assert property (@(posedge clk) disable iff (rst)
    final_beat |=> (!draining && (vld == '0) && !overflow_seen))
    else $error("row not empty after final result");

  // a record arriving at a full row marks the batch
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (in_beat && full) |=> overflow_seen)
    else $error("dropped record not flagged");
`endif

endmodule
